// ===== hdl/sefb_pkg.sv =====
// ----------------------------------------------------------------------------
// sefb_pkg: shared types and constants for the STX/ETX frame builder
// Holds framing bytes, the minimum count, the hex digit encoder and the
// bundle that carries the bytes one input transaction produces.
// ----------------------------------------------------------------------------
package sefb_pkg;

  localparam logic [7:0] STX_BYTE  = 8'h02;
  localparam logic [7:0] ETX_BYTE  = 8'h03;
  localparam logic [7:0] ERR_BYTE  = 8'h00;
  localparam logic [7:0] MIN_COUNT = 8'd4;
  localparam int unsigned MAX_BYTES = 7;
  localparam int unsigned LEN_W     = 3;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]          len;
    logic                      fin;
    logic                      err;
  } sefb_bundle_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = 8'h30 + {4'h0, d};
    end else begin
      r = 8'h37 + {4'h0, d};
    end
    return r;
  endfunction

endpackage

// ===== hdl/sefb_encode.sv =====
// ----------------------------------------------------------------------------
// sefb_encode: frame state and per-transaction byte bundle
// Tracks frame position, running checksum and drop mode, and registers the
// bytes each accepted character produces as one bundle.
// ----------------------------------------------------------------------------
module sefb_encode
  import sefb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   char_in,
  input  logic [7:0]   frame_count,
  input  logic         char_last,
  output sefb_bundle_t pend,
  output logic         pend_valid,
  input  logic         pend_take
);

  logic         inside_frame;
  logic [7:0]   running_sum;
  logic         dropping;
  logic         accept;
  logic         first;
  logic         bad_count;
  logic [7:0]   cnt_hi;
  logic [7:0]   cnt_lo;
  logic [7:0]   sum_new;
  logic [7:0]   chk;
  sefb_bundle_t pend_next;

  assign in_ready  = !pend_valid || pend_take;
  assign accept    = in_valid && in_ready;
  assign first     = !inside_frame;
  assign bad_count = frame_count < MIN_COUNT;
  assign cnt_hi    = hex_digit(frame_count[7:4]);
  assign cnt_lo    = hex_digit(frame_count[3:0]);
  assign sum_new   = first ? (cnt_hi + cnt_lo + char_in) : (running_sum + char_in);
  assign chk       = 8'h00 - sum_new;

  always_comb begin
    pend_next       = '0;
    pend_next.fin   = char_last;
    if (first && bad_count) begin
      pend_next.bytes[0] = ERR_BYTE;
      pend_next.len      = LEN_W'(1);
      pend_next.fin      = 1'b1;
      pend_next.err      = 1'b1;
    end else if (first) begin
      pend_next.bytes[0] = STX_BYTE;
      pend_next.bytes[1] = cnt_hi;
      pend_next.bytes[2] = cnt_lo;
      pend_next.bytes[3] = char_in;
      pend_next.bytes[4] = hex_digit(chk[7:4]);
      pend_next.bytes[5] = hex_digit(chk[3:0]);
      pend_next.bytes[6] = ETX_BYTE;
      pend_next.len      = char_last ? LEN_W'(7) : LEN_W'(4);
    end else begin
      pend_next.bytes[0] = char_in;
      pend_next.bytes[1] = hex_digit(chk[7:4]);
      pend_next.bytes[2] = hex_digit(chk[3:0]);
      pend_next.bytes[3] = ETX_BYTE;
      pend_next.len      = char_last ? LEN_W'(4) : LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame <= 1'b0;
      running_sum  <= 8'h00;
      dropping     <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      if (accept && !dropping) begin
        pend_valid <= 1'b1;
      end else if (pend_take) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        if (dropping) begin
          dropping <= !char_last;
        end else if (first && bad_count) begin
          dropping    <= !char_last;
          running_sum <= 8'h00;
        end else begin
          inside_frame <= !char_last;
          running_sum  <= char_last ? 8'h00 : sum_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !dropping) begin
      pend <= pend_next;
    end
  end

  a_pend_len: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> pend.len != '0)
    else $error("pending bundle is empty");

  a_err_len: assert property (@(posedge clk) disable iff (rst)
    pend_valid && pend.err |-> pend.len == LEN_W'(1) && pend.fin)
    else $error("error bundle malformed");

  a_drop_idle: assert property (@(posedge clk) disable iff (rst)
    dropping |-> !inside_frame)
    else $error("dropping inside an open frame");

endmodule

// ===== hdl/sefb_serial.sv =====
// ----------------------------------------------------------------------------
// sefb_serial: bundle to byte stream
// Holds the current bundle and steps through its bytes into the output
// register, pulling the next bundle as the last byte leaves.
// ----------------------------------------------------------------------------
module sefb_serial
  import sefb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  sefb_bundle_t pend,
  input  logic         pend_valid,
  output logic         pend_take,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   byte_out,
  output logic         frame_end,
  output logic         count_error
);

  sefb_bundle_t     cur;
  logic             cur_valid;
  logic [LEN_W-1:0] idx;
  logic             out_load;
  logic             emit;
  logic             at_end;
  logic             cur_done;

  assign out_load  = !out_valid || out_ready;
  assign emit      = cur_valid && out_load;
  assign at_end    = idx == (cur.len - LEN_W'(1));
  assign cur_done  = emit && at_end;
  assign pend_take = pend_valid && (!cur_valid || cur_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pend_take) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (cur_done) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else if (emit) begin
        idx <= idx + LEN_W'(1);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_take) begin
      cur <= pend;
    end
    if (emit) begin
      byte_out    <= cur.bytes[idx];
      frame_end   <= cur.fin && at_end;
      count_error <= cur.err && at_end;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> idx < cur.len)
    else $error("byte index past bundle length");

  a_err_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && count_error |-> frame_end && byte_out == ERR_BYTE)
    else $error("error result malformed");

  a_take_free: assert property (@(posedge clk) disable iff (rst)
    pend_take && cur_valid |-> cur_done)
    else $error("bundle overwritten before drained");

endmodule

// ===== hdl/stx_etx_frame_builder.sv =====
// ----------------------------------------------------------------------------
// stx_etx_frame_builder: STX/ETX framer with two's complement checksum
// Turns a character stream into framed bytes: STX, count as two hex digits,
// the characters, checksum as two hex digits, ETX.
//
// Input channel (in_valid/in_ready): char_in, frame_count, char_last. The
// count is read on the first character of a frame; char_last closes it.
// A count below four yields one result with count_error and frame_end set
// and the rest of that frame is discarded with no output.
// Output channel (out_valid/out_ready): byte_out, frame_end, count_error,
// one byte per transaction.
// Bytes pass the pending bundle, the current bundle and the output register.
// Throughput: one output byte per cycle while the receiver is ready; a
// transaction yields 1, 4 or 7 bytes (none while a rejected frame's tail
// is dropped). The input takes a new transaction while the previous one
// drains, through a one-bundle holding register in front of the byte
// serializer.
// Reset clears frame state, the pending bundle and the output register.
// When the receiver stalls, the output holds and the input backs up after
// one pending bundle.
// ----------------------------------------------------------------------------
module stx_etx_frame_builder
  import sefb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  input  logic [7:0] frame_count,
  input  logic       char_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] byte_out,
  output logic       frame_end,
  output logic       count_error
);

  sefb_bundle_t pend;
  logic         pend_valid;
  logic         pend_take;

  sefb_encode u_encode (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_in     (char_in),
    .frame_count (frame_count),
    .char_last   (char_last),
    .pend        (pend),
    .pend_valid  (pend_valid),
    .pend_take   (pend_take)
  );

  sefb_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .pend        (pend),
    .pend_valid  (pend_valid),
    .pend_take   (pend_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .byte_out    (byte_out),
    .frame_end   (frame_end),
    .count_error (count_error)
  );

endmodule
